// ----- rtl/core/p6sd_pkg.sv -----
// Package for the packed 6-bit string decoder: result kinds, result record,
// push bundle and the 6-bit code to ASCII map. No dependencies.
`timescale 1ns / 1ps

package p6sd_pkg;

  localparam int unsigned LenMaxBytes = 10;   // longest LEB128 length prefix
  localparam int unsigned ResDepth    = 4;    // result queue entries (power of two, >= 2)
  localparam int unsigned LenWidth    = 64;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_LONG  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] char_value;
    logic       last;
  } res_t;

  // up to two results from one input byte, in order r0 then r1
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  // 0-9, '|', ',', A-V, then a onward
  function automatic logic [6:0] ascii_of(input logic [5:0] code);
    logic [6:0] c;
    c = {1'b0, code};
    case (code) inside
      [6'd0 : 6'd9]:   ascii_of = c + 7'h30;
      6'd10:           ascii_of = 7'h7C;
      6'd11:           ascii_of = 7'h2C;
      [6'd12 : 6'd33]: ascii_of = c + 7'h35;
      default:         ascii_of = c + 7'h3F;
    endcase
  endfunction

endpackage

// ----- rtl/core/p6sd_if.sv -----
// Request channels of the packed 6-bit string decoder: input byte and result.
// Valid/ready handshake; no package dependency.
`timescale 1ns / 1ps

interface p6sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface p6sd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] char_value;
  logic       last;

  modport source (output valid, output kind, output char_value, output last, input ready);
  modport sink   (input valid, input kind, input char_value, input last, output ready);
endinterface

// ----- rtl/core/packed_6bit_string_decoder.sv -----
// Top level of the packed 6-bit string decoder.
// Depends on p6sd_pkg, p6sd_if, p6sd_decode and p6sd_res_fifo.
//
//   channel  dir  payload                      request accepted when
//   in_i     in   in_byte[7:0]                 valid && ready
//   out_o    out  kind[1:0] char_value[6:0]    valid && ready
//                 last
//
// A byte is decoded in the cycle it is accepted; its results (0..2) enter the
// result queue at that edge and can leave from the next cycle, one per cycle.
// Input ready depends only on the queue having room for two results, so one
// byte per cycle is taken while output keeps up; bytes giving two results are
// limited by the single output port. Reset clears the decode state and queue.
`timescale 1ns / 1ps

module packed_6bit_string_decoder
  import p6sd_pkg::*;
#(
  parameter int unsigned ResQueueDepth = ResDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  p6sd_in_if.sink      in_i,
  p6sd_out_if.source   out_o
);

  push_t push;
  logic  room2;
  logic  take;
  res_t  res;

  assign in_i.ready = room2;
  assign take       = in_i.valid && room2;

  p6sd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_i.in_byte),
    .push_o (push)
  );

  p6sd_res_fifo #(
    .Depth (ResQueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.kind       = res.kind;
  assign out_o.char_value = res.char_value;
  assign out_o.last       = res.last;

endmodule

// ----- rtl/core/p6sd_decode.sv -----
// Decoder state and one-pass byte step: LEB128 length, then 6-bit unpacking.
// Depends on p6sd_pkg.
`timescale 1ns / 1ps

module p6sd_decode
  import p6sd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  byte_i,
  output push_t       push_o
);

  localparam int unsigned CntW = $clog2(LenMaxBytes);

  logic                payload_q, payload_d;
  logic [CntW-1:0]     lcnt_q, lcnt_d;
  logic [LenWidth-1:0] length_q, length_d;
  logic [LenWidth-1:0] chars_q, chars_d;
  logic [3:0]          bit_acc_q, bit_acc_d;
  logic [2:0]          bc_q, bc_d;      // held bits: 0, 2 or 4

  logic [6:0]          shamt7;
  logic [LenWidth-1:0] len_new;
  logic [11:0]         acc_w;
  logic [3:0]          cnt_w;
  logic                two;
  logic [LenWidth-1:0] chars_rem;

  always_comb begin
    payload_d = payload_q;
    lcnt_d    = lcnt_q;
    length_d  = length_q;
    chars_d   = chars_q;
    bit_acc_d = bit_acc_q;
    bc_d      = bc_q;
    push_o    = '0;

    shamt7    = {lcnt_q, 3'b000} - 7'(lcnt_q);   // lcnt * 7
    len_new   = length_q | (LenWidth'(byte_i[6:0]) << shamt7[5:0]);
    acc_w     = 12'(bit_acc_q) | (12'(byte_i) << bc_q);
    cnt_w     = 4'(bc_q) + 4'd8;
    two       = (cnt_w >= 4'd12) && (chars_q[LenWidth-1:1] != '0);
    chars_rem = chars_q - (two ? LenWidth'(2) : LenWidth'(1));

    if (take_i) begin
      if (!payload_q) begin
        if (!byte_i[7]) begin
          length_d = '0;
          lcnt_d   = '0;
          if (len_new == '0) begin
            push_o.v0 = 1'b1;
            push_o.r0 = '{kind: KIND_EMPTY, char_value: 7'd0, last: 1'b1};
          end else begin
            chars_d   = len_new;
            bit_acc_d = '0;
            bc_d      = '0;
            payload_d = 1'b1;
          end
        end else if (lcnt_q == CntW'(LenMaxBytes - 1)) begin
          // continuation still set on the last allowed length byte
          length_d  = '0;
          lcnt_d    = '0;
          push_o.v0 = 1'b1;
          push_o.r0 = '{kind: KIND_LONG, char_value: 7'd0, last: 1'b1};
        end else begin
          length_d = len_new;
          lcnt_d   = lcnt_q + CntW'(1);
        end
      end else begin
        // a payload byte always completes at least one character
        push_o.v0 = 1'b1;
        push_o.r0 = '{kind: KIND_CHAR, char_value: ascii_of(acc_w[5:0]),
                      last: (chars_q == LenWidth'(1))};
        if (two) begin
          push_o.v1 = 1'b1;
          push_o.r1 = '{kind: KIND_CHAR, char_value: ascii_of(acc_w[11:6]),
                        last: (chars_q == LenWidth'(2))};
        end
        if (chars_rem == '0) begin
          payload_d = 1'b0;
          chars_d   = '0;
          bit_acc_d = '0;
          bc_d      = '0;
        end else begin
          chars_d = chars_rem;
          if (two) begin
            bit_acc_d = '0;
            bc_d      = '0;
          end else begin
            bit_acc_d = acc_w[9:6];
            bc_d      = 3'(cnt_w - 4'd6);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_q <= 1'b0;
      lcnt_q    <= '0;
      length_q  <= '0;
      chars_q   <= '0;
      bit_acc_q <= '0;
      bc_q      <= '0;
    end else begin
      payload_q <= payload_d;
      lcnt_q    <= lcnt_d;
      length_q  <= length_d;
      chars_q   <= chars_d;
      bit_acc_q <= bit_acc_d;
      bc_q      <= bc_d;
    end
  end

endmodule

// ----- rtl/core/p6sd_res_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per cycle while ready_i is high.
// Depends on p6sd_pkg.
`timescale 1ns / 1ps

module p6sd_res_fifo
  import p6sd_pkg::*;
#(
  parameter int unsigned Depth = ResDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room2_o,     // space for two more results
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  res_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;
  logic [1:0]      n_push;
  logic [PtrW-1:0] wp1;

  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rp_q];
  assign room2_o = (cnt_q <= CntW'(Depth - 2));
  assign pop     = valid_o && ready_i;
  assign wp1     = wp_q + PtrW'(1);
  assign n_push  = 2'(push_i.v0) + 2'(push_i.v1);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wp_q] <= push_i.r0;
    if (push_i.v1) mem_q[wp1]  <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PtrW'(n_push);
      if (pop) rp_q <= rp_q + PtrW'(1);
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(pop);
    end
  end

endmodule
